FILE: hw/rtl/dlc_pkg.sv
// Shared types and constants of the distance link contact generator.
`default_nettype none
package dlc_pkg;

  localparam int unsigned LEN_W   = 32;
  localparam int unsigned REST_W  = 17;
  localparam int unsigned NORM_W  = 18;
  localparam int unsigned QUOT_W  = 17;
  localparam int unsigned PEN_W   = 32;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned IDX_W   = 2;

  localparam logic [REST_W-1:0] REST_ONE = 17'd65536;
  localparam logic [PEN_W-1:0]  PEN_MAX  = 32'hFFFF_FFFF;

  typedef enum logic [IDX_W-1:0] {
    REG_LINK_MODE   = 2'd0,
    REG_LINK_LENGTH = 2'd1,
    REG_CABLE_REST  = 2'd2
  } reg_idx_e;

  typedef enum logic {
    MODE_CABLE = 1'b0,
    MODE_ROD   = 1'b1
  } link_mode_e;

  typedef struct packed {
    link_mode_e        mode;
    logic [LEN_W-1:0]  length;
    logic [REST_W-1:0] rest;
  } cfg_t;

  typedef struct packed {
    logic push;
    logic full;
  } q_wr_t;

endpackage
`default_nettype wire

FILE: hw/rtl/dlc_pos_if.sv
// Input channel: two endpoint positions of one link.
`default_nettype none
interface dlc_pos_if #(
  parameter int unsigned CW = 32
);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] pos_a_x;
  logic signed [CW-1:0] pos_a_y;
  logic signed [CW-1:0] pos_a_z;
  logic signed [CW-1:0] pos_b_x;
  logic signed [CW-1:0] pos_b_y;
  logic signed [CW-1:0] pos_b_z;

  modport source (output valid, pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z,
                  input ready);
  modport sink   (input valid, pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z,
                  output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/dlc_contact_if.sv
// Output channel: one contact result per link.
`default_nettype none
interface dlc_contact_if;
  logic               valid;
  logic               ready;
  logic               contact_valid;
  logic signed [17:0] normal_x;
  logic signed [17:0] normal_y;
  logic signed [17:0] normal_z;
  logic [31:0]        penetration;
  logic [16:0]        contact_restitution;

  modport source (output valid, contact_valid, normal_x, normal_y, normal_z, penetration,
                  contact_restitution, input ready);
  modport sink   (input valid, contact_valid, normal_x, normal_y, normal_z, penetration,
                  contact_restitution, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/dlc_front.sv
// Front pipeline: difference, squares, bitwise square root and contact classification.
`default_nettype none
module dlc_front #(
  parameter int unsigned CW = 32,
  parameter int unsigned QW = 64
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  dlc_pos_if.sink           pos_in,
  input  wire dlc_pkg::cfg_t cfg_i,
  input  wire logic         full_i,
  output logic              push_o,
  output logic [QW-1:0]     data_o
);
  import dlc_pkg::*;

  localparam int unsigned MW  = CW + 1;
  localparam int unsigned LW  = MW + 1;
  localparam int unsigned SW  = 2 * LW;
  localparam int unsigned RW  = LW + 3;
  localparam int unsigned XW  = (LW > LEN_W) ? LW : LEN_W;
  localparam int unsigned NST = LW + 4;
  localparam int unsigned SQ0 = 2;

  logic              en;
  logic [NST-1:0]    vld_q;
  logic [3*MW-1:0]   dv_q [NST];
  logic [2*MW-1:0]   sq_q [3];
  logic [RW-1:0]     rem_q [SQ0+LW+1];
  logic [LW-1:0]     root_q [SQ0+LW+1];
  logic [SW-1:0]     sh_q [SQ0+LW+1];

  logic              contact_q, flip_q;
  logic [PEN_W-1:0]  pen_q;
  logic [REST_W-1:0] rest_q;
  logic [LW-1:0]     len_q;

  logic signed [MW-1:0] dx, dy, dz;
  logic [MW-1:0]        mx, my, mz;
  logic [LW-1:0]        len_c;
  logic [XW-1:0]        len_x, lim_x, diff_x;
  logic                 contact_c, flip_c;
  logic [PEN_W-1:0]     pen_c;
  logic [REST_W-1:0]    rest_c;

  assign en           = !vld_q[NST-1] || !full_i;
  assign pos_in.ready = en;
  assign push_o       = vld_q[NST-1] && !full_i;
  assign data_o       = {contact_q, flip_q, pen_q, rest_q, len_q, dv_q[NST-1]};

  assign dx = {pos_in.pos_b_x[CW-1], pos_in.pos_b_x} - {pos_in.pos_a_x[CW-1], pos_in.pos_a_x};
  assign dy = {pos_in.pos_b_y[CW-1], pos_in.pos_b_y} - {pos_in.pos_a_y[CW-1], pos_in.pos_a_y};
  assign dz = {pos_in.pos_b_z[CW-1], pos_in.pos_b_z} - {pos_in.pos_a_z[CW-1], pos_in.pos_a_z};

  always_comb begin
    logic [MW-1:0] d0, d1, d2;
    d0 = dv_q[0][MW-1:0];
    d1 = dv_q[0][2*MW-1:MW];
    d2 = dv_q[0][3*MW-1:2*MW];
    mx = d0[MW-1] ? MW'(-d0) : d0;
    my = d1[MW-1] ? MW'(-d1) : d1;
    mz = d2[MW-1] ? MW'(-d2) : d2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], pos_in.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_q[0]      <= {dz, dy, dx};
      dv_q[1]      <= dv_q[0];
      sq_q[0]      <= mx * mx;
      sq_q[1]      <= my * my;
      sq_q[2]      <= mz * mz;
      dv_q[SQ0]    <= dv_q[1];
      sh_q[SQ0]    <= SW'(sq_q[0]) + SW'(sq_q[1]) + SW'(sq_q[2]);
      rem_q[SQ0]   <= '0;
      root_q[SQ0]  <= '0;
    end
  end

  for (genvar k = 1; k <= LW; k++) begin : g_sqrt
    logic [RW-1:0] rem2, trial;
    logic          ge;
    assign rem2  = {rem_q[SQ0+k-1][RW-3:0], sh_q[SQ0+k-1][SW-1 -: 2]};
    assign trial = {1'b0, root_q[SQ0+k-1], 2'b01};
    assign ge    = rem2 >= trial;
    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_q[SQ0+k]   <= dv_q[SQ0+k-1];
        rem_q[SQ0+k]  <= ge ? (rem2 - trial) : rem2;
        root_q[SQ0+k] <= {root_q[SQ0+k-1][LW-2:0], ge};
        sh_q[SQ0+k]   <= {sh_q[SQ0+k-1][SW-3:0], 2'b00};
      end
    end
  end

  always_comb begin
    len_c     = root_q[SQ0+LW];
    len_x     = XW'(len_c);
    lim_x     = XW'(cfg_i.length);
    flip_c    = 1'b0;
    rest_c    = '0;
    diff_x    = len_x - lim_x;
    if (cfg_i.mode == MODE_CABLE) begin
      contact_c = len_x >= lim_x;
      rest_c    = (cfg_i.rest > REST_ONE) ? REST_ONE : cfg_i.rest;
    end else begin
      contact_c = len_x != lim_x;
      if (len_x <= lim_x) begin
        diff_x = lim_x - len_x;
        flip_c = 1'b1;
      end
    end
    pen_c = (diff_x > XW'(PEN_MAX)) ? PEN_MAX : diff_x[PEN_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_q[NST-1] <= dv_q[NST-2];
      contact_q   <= contact_c;
      flip_q      <= flip_c;
      pen_q       <= pen_c;
      rest_q      <= rest_c;
      len_q       <= len_c;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/dlc_queue.sv
// Short register queue between the front and back pipelines.
`default_nettype none
module dlc_queue #(
  parameter int unsigned W     = 64,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire dlc_pkg::q_wr_t wr_i,
  output logic              full_o,
  input  wire logic [W-1:0] data_i,
  input  wire logic         pop_i,
  output logic              empty_o,
  output logic [W-1:0]      data_o
);
  import dlc_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  mem_q [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [PW:0]   cnt_q;

  assign full_o  = cnt_q == (PW+1)'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (wr_i.push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_i.push) begin
        wr_q <= (wr_q == PW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (PW+1)'(wr_i.push) - (PW+1)'(pop_i);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_i.push && full_o)) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o)) else $error("queue read while empty");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PW+1)'(DEPTH)) else $error("queue count out of range");
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_i.push && !pop_i) |=> !empty_o) else $error("queue lost a transfer");

endmodule
`default_nettype wire

FILE: hw/rtl/dlc_back.sv
// Back pipeline: restoring division for the unit normal and output register.
`default_nettype none
module dlc_back #(
  parameter int unsigned CW = 32,
  parameter int unsigned QW = 64
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          empty_i,
  input  wire logic [QW-1:0] data_i,
  output logic               pop_o,
  dlc_contact_if.source      contact_out
);
  import dlc_pkg::*;

  localparam int unsigned MW = CW + 1;
  localparam int unsigned LW = MW + 1;
  localparam int unsigned IW = 2 + PEN_W + REST_W + LW + 3;
  localparam int unsigned NB = QUOT_W + 1;

  logic           en;
  logic [NB-1:0]  vld_q;
  logic [IW-1:0]  info_q [NB-1];
  logic [LW-1:0]  r_q [NB-1][3];
  logic [QUOT_W-1:0] q_q [NB-1][3];

  logic              contact_i, flip_i;
  logic [PEN_W-1:0]  pen_i;
  logic [REST_W-1:0] rest_i;
  logic [LW-1:0]     len_i;
  logic [3*MW-1:0]   dv_i;

  assign {contact_i, flip_i, pen_i, rest_i, len_i, dv_i} = data_i;

  assign en    = !vld_q[NB-1] || contact_out.ready;
  assign pop_o = en && !empty_i;
  assign contact_out.valid = vld_q[NB-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NB-2:0], !empty_i};
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_lane
    logic [MW-1:0] d, a;
    logic          ge0;
    assign d   = dv_i[c*MW +: MW];
    assign a   = d[MW-1] ? MW'(-d) : d;
    assign ge0 = LW'(a) >= len_i;
    always_ff @(posedge clk_i) begin
      if (en) begin
        r_q[0][c] <= ge0 ? (LW'(a) - len_i) : LW'(a);
        q_q[0][c] <= QUOT_W'(ge0);
      end
    end
    for (genvar k = 1; k < NB-1; k++) begin : g_step
      logic [LW:0]   r2;
      logic [LW-1:0] len;
      logic          ge;
      assign len = info_q[k-1][LW+2:3];
      assign r2  = {r_q[k-1][c], 1'b0};
      assign ge  = r2 >= (LW+1)'(len);
      always_ff @(posedge clk_i) begin
        if (en) begin
          r_q[k][c] <= ge ? LW'(r2 - (LW+1)'(len)) : r2[LW-1:0];
          q_q[k][c] <= {q_q[k-1][c][QUOT_W-2:0], ge};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      info_q[0] <= {contact_i, flip_i, pen_i, rest_i, len_i,
                    dv_i[3*MW-1], dv_i[2*MW-1], dv_i[MW-1]};
      for (int k = 1; k < NB-1; k++) begin
        info_q[k] <= info_q[k-1];
      end
    end
  end

  logic              f_contact, f_flip;
  logic [PEN_W-1:0]  f_pen;
  logic [REST_W-1:0] f_rest;
  logic [LW-1:0]     f_len;
  logic [2:0]        f_sgn;
  logic [NORM_W-1:0] f_n [3];

  assign {f_contact, f_flip, f_pen, f_rest, f_len, f_sgn} = info_q[NB-2];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (!f_contact || f_len == '0) begin
        f_n[c] = '0;
      end else if (f_sgn[c] != f_flip) begin
        f_n[c] = -NORM_W'(q_q[NB-2][c]);
      end else begin
        f_n[c] = NORM_W'(q_q[NB-2][c]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      contact_out.contact_valid       <= f_contact;
      contact_out.normal_x            <= f_n[0];
      contact_out.normal_y            <= f_n[1];
      contact_out.normal_z            <= f_n[2];
      contact_out.penetration         <= f_contact ? f_pen : '0;
      contact_out.contact_restitution <= f_contact ? f_rest : '0;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/distance_link_contact.sv
// Top level of the distance link contact generator.
// Usage:
//   pos_in carries the two endpoint positions (signed Q16.16) of one link;
//   contact_out returns one result per input transfer, in order.
//   Configuration (mode, length, cable restitution) is written through
//   cfg_we_i / cfg_idx_i / cfg_data_i while no link is in flight.
// Throughput: one transfer per cycle in both directions while neither side is stalled.
// Pipeline: one square-root stage per root bit (COORD_WIDTH + 2) in the front,
//   17 quotient stages plus the output register in the back.
// A four-entry queue sits between the front and back pipelines; each stalls
//   on its own. A stalled receiver holds the output register and the back
//   pipeline; the front keeps accepting until the queue fills.
// Reset clears all valid flags and loads cable mode, length 1.0 and
//   restitution 0; it takes effect at once with no clearing pass.
`default_nettype none
module distance_link_contact #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  dlc_pos_if.sink                          pos_in,
  dlc_contact_if.source                    contact_out,
  input  wire logic                        cfg_we_i,
  input  wire logic [dlc_pkg::IDX_W-1:0]   cfg_idx_i,
  input  wire logic [dlc_pkg::CFG_W-1:0]   cfg_data_i
);
  import dlc_pkg::*;

  localparam int unsigned MW = COORD_WIDTH + 1;
  localparam int unsigned LW = MW + 1;
  localparam int unsigned QW = 2 + PEN_W + REST_W + LW + 3 * MW;

  cfg_t          cfg_q;
  q_wr_t         qwr;
  logic          q_full, q_pop, q_empty;
  logic [QW-1:0] f_data, q_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode   <= MODE_CABLE;
      cfg_q.length <= 32'd65536;
      cfg_q.rest   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LINK_MODE:   cfg_q.mode   <= link_mode_e'(cfg_data_i[0]);
        REG_LINK_LENGTH: cfg_q.length <= cfg_data_i[LEN_W-1:0];
        REG_CABLE_REST:  cfg_q.rest   <= cfg_data_i[REST_W-1:0];
        default: ;
      endcase
    end
  end

  assign qwr.full = q_full;

  dlc_front #(.CW(COORD_WIDTH), .QW(QW)) u_front (
    .clk_i, .rst_ni, .pos_in, .cfg_i(cfg_q), .full_i(q_full),
    .push_o(qwr.push), .data_o(f_data)
  );

  dlc_queue #(.W(QW), .DEPTH(4)) u_queue (
    .clk_i, .rst_ni, .wr_i(qwr), .full_o(q_full), .data_i(f_data),
    .pop_i(q_pop), .empty_o(q_empty), .data_o(q_data)
  );

  dlc_back #(.CW(COORD_WIDTH), .QW(QW)) u_back (
    .clk_i, .rst_ni, .empty_i(q_empty), .data_i(q_data), .pop_o(q_pop), .contact_out
  );

endmodule
`default_nettype wire

FILE: tb/dlc_checker.sv
// Checker: predicts contact results from observed input transfers and compares.
`timescale 1ns / 1ps
module dlc_checker (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  dlc_pos_if.sink            pos_mon,
  dlc_contact_if.sink        con_mon,
  input  wire logic          cfg_we_i,
  input  wire logic [1:0]    cfg_idx_i,
  input  wire logic [31:0]   cfg_data_i,
  output int                 fail_cnt_o,
  output int                 pending_o
);
  import dlc_pkg::*;

  typedef struct packed {
    logic        hit;
    logic [17:0] nx;
    logic [17:0] ny;
    logic [17:0] nz;
    logic [31:0] pen;
    logic [16:0] rest;
  } contact_t;

  contact_t   contacts_due[$];
  link_mode_e mode_q;
  logic [31:0] length_q;
  logic [16:0] rest_q;

  assign pending_o = contacts_due.size();

  function automatic logic [17:0] unit_comp(logic signed [33:0] d, logic [63:0] len,
                                            logic flip);
    logic [63:0] a;
    logic [63:0] r;
    logic [17:0] q;
    q = '0;
    if (len == 0) return '0;
    a = (d < 0) ? 64'(-d) : 64'(d);
    if (a >= len) begin
      q = 1;
      r = a - len;
    end else begin
      r = a;
    end
    for (int i = 0; i < 16; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= len) begin
        r = r - len;
        q[0] = 1'b1;
      end
    end
    if ((d < 0) != flip) q = -q;
    return q;
  endfunction

  function automatic contact_t link_contact(logic signed [31:0] ax, ay, az, bx, by, bz);
    logic signed [33:0] d [3];
    logic [67:0] sq;
    logic [63:0] len;
    logic [63:0] c;
    logic [63:0] pen;
    logic [63:0] lk;
    logic flip;
    logic hit;
    contact_t res;
    d[0] = 34'(bx) - 34'(ax);
    d[1] = 34'(by) - 34'(ay);
    d[2] = 34'(bz) - 34'(az);
    sq = 0;
    for (int i = 0; i < 3; i++) sq += 68'(68'(d[i]) * 68'(d[i]));
    len = 0;
    for (int b = 63; b >= 0; b--) begin
      c = len | (64'd1 << b);
      if (128'(c) * 128'(c) <= 128'(sq)) len = c;
    end
    lk = 64'(length_q);
    flip = 1'b0;
    res = '0;
    if (mode_q == MODE_CABLE) begin
      hit = len >= lk;
      pen = hit ? len - lk : 0;
      res.rest = (rest_q > REST_ONE) ? REST_ONE : rest_q;
    end else begin
      hit = len != lk;
      if (len > lk) pen = len - lk;
      else begin
        pen = lk - len;
        flip = 1'b1;
      end
    end
    if (!hit) return '0;
    res.hit = 1'b1;
    res.pen = (pen > 64'(PEN_MAX)) ? PEN_MAX : pen[31:0];
    res.nx = unit_comp(d[0], len, flip);
    res.ny = unit_comp(d[1], len, flip);
    res.nz = unit_comp(d[2], len, flip);
    return res;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    fail_cnt_o++;
  endtask

  initial fail_cnt_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    contact_t w;
    if (!rst_ni) begin
      mode_q   <= MODE_CABLE;
      length_q <= 32'd65536;
      rest_q   <= '0;
    end else begin
      if (con_mon.valid && con_mon.ready) begin
        if (contacts_due.size() == 0) begin
          report("unexpected transfer", 0, 0);
        end else begin
          w = contacts_due.pop_front();
          if (con_mon.contact_valid !== w.hit) report("contact_valid", con_mon.contact_valid, w.hit);
          if (con_mon.normal_x !== w.nx) report("normal_x", con_mon.normal_x, w.nx);
          if (con_mon.normal_y !== w.ny) report("normal_y", con_mon.normal_y, w.ny);
          if (con_mon.normal_z !== w.nz) report("normal_z", con_mon.normal_z, w.nz);
          if (con_mon.penetration !== w.pen) report("penetration", con_mon.penetration, w.pen);
          if (con_mon.contact_restitution !== w.rest)
            report("restitution", con_mon.contact_restitution, w.rest);
        end
      end
      if (pos_mon.valid && pos_mon.ready)
        contacts_due.push_back(link_contact(pos_mon.pos_a_x, pos_mon.pos_a_y, pos_mon.pos_a_z,
                                            pos_mon.pos_b_x, pos_mon.pos_b_y, pos_mon.pos_b_z));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_LINK_MODE:   mode_q <= link_mode_e'(cfg_data_i[0]);
          REG_LINK_LENGTH: length_q <= cfg_data_i;
          REG_CABLE_REST:  rest_q <= cfg_data_i[16:0];
          default: ;
        endcase
      end
    end
  end
endmodule

FILE: tb/tb_distance_link_contact.sv
// Testbench top: drives links and configuration, reports the verdict.
`timescale 1ns / 1ps
module tb_distance_link_contact;
  import dlc_pkg::*;

  localparam int LATENCY = 32 + 24;
  localparam int LIMIT = 400000;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_we_i = 0;
  logic [1:0] cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  int fail_cnt;
  int pending;
  int cycles = 0;
  int send_idle = 0;
  int recv_stall = 0;

  dlc_pos_if #(.CW(32)) pos_ch ();
  dlc_contact_if con_ch ();

  distance_link_contact #(.COORD_WIDTH(32)) dut (
    .clk_i, .rst_ni, .pos_in(pos_ch.sink), .contact_out(con_ch.source),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  dlc_checker chk (
    .clk_i, .rst_ni, .pos_mon(pos_ch.sink), .con_mon(con_ch.sink),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i, .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    pos_ch.valid = 0;
    {pos_ch.pos_a_x, pos_ch.pos_a_y, pos_ch.pos_a_z} = '0;
    {pos_ch.pos_b_x, pos_ch.pos_b_y, pos_ch.pos_b_z} = '0;
    con_ch.ready = 0;
  end

  always @(negedge clk_i) con_ch.ready <= ($urandom_range(99) >= recv_stall);

  task automatic write_reg(reg_idx_e idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain;
    while (pending != 0) @(negedge clk_i);
    repeat (LATENCY + 4) @(negedge clk_i);
  endtask

  task automatic send_link(logic [31:0] ax, ay, az, bx, by, bz);
    while ($urandom_range(99) < send_idle) begin
      pos_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    pos_ch.valid <= 1'b1;
    pos_ch.pos_a_x <= ax; pos_ch.pos_a_y <= ay; pos_ch.pos_a_z <= az;
    pos_ch.pos_b_x <= bx; pos_ch.pos_b_y <= by; pos_ch.pos_b_z <= bz;
    @(posedge clk_i);
    while (!pos_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord(int kind);
    case (kind)
      0: return $urandom;
      1: return 32'($signed($urandom_range(2 * 65536 * 4)) - 65536 * 4);
      default: return 32'($signed($urandom_range(2 * 65536 * 200)) - 65536 * 200);
    endcase
  endfunction

  task automatic random_links(int n);
    int k;
    logic [31:0] ax, ay, az, lx, ly, lz;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(9);
      ax = $urandom; ay = $urandom; az = $urandom;
      if (k < 2) begin
        send_link(ax, ay, az, $urandom, $urandom, $urandom);
      end else if (k < 3) begin
        lx = (k == 2 && $urandom_range(1)) ? 32'd65536 : 32'd0;
        send_link(ax, ay, az, ax + lx, ay, az);
      end else begin
        lx = rand_coord(k % 3); ly = rand_coord(1); lz = rand_coord(2);
        send_link(ax, ay, az, ax + lx, ay + ly, az + lz);
      end
    end
    pos_ch.valid <= 1'b0;
  endtask

  initial begin
    logic [31:0] lens [6];
    lens = '{32'd0, 32'd65536, 32'd131072, 32'h0010_0000, 32'h00C8_0000, 32'hFFFF_FFFF};
    repeat (10) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);
    // directed: extremes, zero distance, exact length, saturation, axis normals
    send_link(0, 0, 0, 0, 0, 0);
    send_link(0, 0, 0, 32'd65536, 0, 0);
    send_link(0, 0, 0, 0, -32'sd65536, 0);
    send_link(0, 0, 0, 0, 0, 32'd200000);
    send_link(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_link(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_link(32'hFFFF_FFFF, 1, 32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFE, 0);
    send_link(0, 0, 0, 32'd30000, 32'd40000, 32'd50000);
    pos_ch.valid <= 1'b0;
    drain();
    write_reg(REG_CABLE_REST, 32'h1FFFF);
    write_reg(REG_LINK_LENGTH, 32'd0);
    send_link(0, 0, 0, 0, 0, 0);
    send_link(5, 5, 5, 5, 5, 6);
    pos_ch.valid <= 1'b0;
    drain();
    write_reg(REG_LINK_MODE, MODE_ROD);
    write_reg(REG_LINK_LENGTH, 32'hFFFF_FFFF);
    send_link(0, 0, 0, 0, 0, 0);
    send_link(0, 0, 0, 32'd65536, 32'd1, 32'h7FFF_FFFF);
    pos_ch.valid <= 1'b0;
    drain();
    write_reg(REG_LINK_LENGTH, 32'd65536);
    send_link(0, 0, 0, 32'd65536, 0, 0);
    send_link(0, 0, 0, 0, 32'd32768, 0);
    pos_ch.valid <= 1'b0;
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 47; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 47; end
        default: begin send_idle = 15; recv_stall = 15; end
      endcase
      write_reg(REG_LINK_MODE, (ph % 2) ? MODE_ROD : MODE_CABLE);
      write_reg(REG_LINK_LENGTH, lens[$urandom_range(5)]);
      write_reg(REG_CABLE_REST, $urandom_range(3) == 0 ? 32'd65536 : $urandom_range(32'h1FFFF));
      random_links(215);
      drain();
    end
    send_idle = 0;
    recv_stall = 0;
    drain();
    if (fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
